[design/tff_pkg.sv]
// Shared constants and types for the timestamped frame FIFO.
`default_nettype none
package tff_pkg;
    localparam int CAPACITY_DEF = 64;
    localparam int FRAME_BITS_DEF = 64;
    localparam int POS_W = 48;
    localparam int CNT_W = 7;
    localparam int MAX_RES = 64;

    localparam logic [2:0] OP_WRITE_BEGIN = 3'd0;
    localparam logic [2:0] OP_WRITE_DATA  = 3'd1;
    localparam logic [2:0] OP_PUBLISH_GAP = 3'd2;
    localparam logic [2:0] OP_READ        = 3'd3;
    localparam logic [2:0] OP_EXPIRE      = 3'd4;
    localparam logic [2:0] OP_CAN_WRITE   = 3'd5;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CAN   = 2'd2;

    typedef logic [POS_W-1:0] pos_t;
endpackage
`default_nettype wire

[design/timestamped_frame_fifo.sv]
// Top level: ring FIFO of timestamped audio frames.
// write_begin (not zero-fill) and can_write results register at the accepting edge, valid next cycle.
// Throughput: one write/publish/can_write request per cycle while the output is not stalled;
// a zero-fill write blocks input until filled and posted. Reads and expires drop entries below
// the target; a read checks ends and marks, then emits exact frames or a zero result per free cycle.
// Reset clears counters, horizons and the open write; memory contents are undefined until written.
`default_nettype none
module timestamped_frame_fifo #(
    parameter int CAPACITY = tff_pkg::CAPACITY_DEF,
    parameter int FRAME_BITS = tff_pkg::FRAME_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  opcode,
    input  wire logic [47:0] first_frame,
    input  wire logic [6:0]  frame_count,
    input  wire logic [47:0] until_frame,
    input  wire logic        mark_discontinuity,
    input  wire logic        zero_fill,
    input  wire logic [63:0] frame_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       result_kind,
    output logic             ok,
    output logic [63:0]      frame_data_res,
    output logic             exact,
    output logic             discontinuity,
    output logic             last
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RW = AW + 1;
    localparam int CW = tff_pkg::CNT_W;
    localparam logic [RW-1:0] RING_M1 = RW'(2 * CAPACITY - 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISC_A = 4'd1;  // issue read at read_count
    localparam logic [3:0] S_DISC_B = 4'd2;  // compare position
    localparam logic [3:0] S_CHK_A  = 4'd3;  // read first entry position
    localparam logic [3:0] S_CHK_B  = 4'd4;
    localparam logic [3:0] S_MARK_A = 4'd5;
    localparam logic [3:0] S_MARK_B = 4'd6;
    localparam logic [3:0] S_EMIT_A = 4'd7;
    localparam logic [3:0] S_EMIT_B = 4'd8;
    localparam logic [3:0] S_ZEROS  = 4'd9;
    localparam logic [3:0] S_FILL   = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [FRAME_BITS-1:0] pay_mem [CAPACITY];
    tff_pkg::pos_t         pos_mem [CAPACITY];
    logic                  mark_mem [CAPACITY];

    logic [3:0] state_reg, state_next;
    logic [RW-1:0] wc_reg, wc_next, rc_reg, rc_next;
    tff_pkg::pos_t pub_reg, pub_next, req_reg, req_next;
    logic pa_reg, pa_next;
    logic [CW-1:0] prem_reg, prem_next;
    tff_pkg::pos_t pstart_reg, pstart_next;
    logic [RW-1:0] pidx_reg, pidx_next;
    logic pmark_reg, pmark_next;

    // operation context
    logic [1:0] op2_reg, op2_next;  // 0 first discard to start, 1 discard to end
    tff_pkg::pos_t target_reg, target_next, ostart_reg, ostart_next;
    tff_pkg::pos_t oend_reg, oend_next;
    logic [CW-1:0] ocnt_reg, ocnt_next, i_reg, i_next;
    logic omark_reg, omark_next, disc_reg, disc_next;
    logic [RW-1:0] fidx_reg, fidx_next;
    logic ret_read_reg, ret_read_next;  // discard belongs to a read

    // memory port
    logic rd_en;
    logic [AW-1:0] rd_addr;
    tff_pkg::pos_t rd_pos;
    logic [FRAME_BITS-1:0] rd_pay;
    logic rd_mark;
    logic wr_en;
    logic [AW-1:0] wr_addr;
    logic [FRAME_BITS-1:0] wr_pay;
    tff_pkg::pos_t wr_pos;
    logic wr_mark;

    // output register
    logic ov_reg, ov_next;
    logic [1:0] kind_reg, kind_next;
    logic ok_reg, ok_next, ex_reg, ex_next, dc_reg, dc_next, la_reg, la_next;
    logic [FRAME_BITS-1:0] dat_reg, dat_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pay_mem[wr_addr] <= wr_pay;
            pos_mem[wr_addr] <= wr_pos;
            mark_mem[wr_addr] <= wr_mark;
        end
        if (rd_en)
        begin
            rd_pay <= pay_mem[rd_addr];
            rd_pos <= pos_mem[rd_addr];
            rd_mark <= mark_mem[rd_addr];
        end
    end

    function automatic logic [AW-1:0] slot(input logic [RW-1:0] idx);
        logic [AW-1:0] r;
        if ((2 ** AW) == CAPACITY)
            r = idx[AW-1:0];
        else if ({1'b0, idx} >= (RW+1)'(CAPACITY))
            r = AW'({1'b0, idx} - (RW+1)'(CAPACITY));
        else
            r = idx[AW-1:0];
        return r;
    endfunction

    function automatic logic [RW-1:0] ring_add(input logic [RW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [RW+CW:0] s;
        s = (RW+CW+1)'(a) + (RW+CW+1)'(b);
        if (s >= (RW+CW+1)'(2 * CAPACITY))
            s = s - (RW+CW+1)'(2 * CAPACITY);
        return s[RW-1:0];
    endfunction

    logic [RW-1:0] occ;
    logic [CW-1:0] room;
    logic slot_free;
    tff_pkg::pos_t in_end;
    logic in_fire, out_busy;

    always_comb
    begin
        if (wc_reg >= rc_reg)
            occ = wc_reg - rc_reg;
        else
            occ = wc_reg + RING_M1 + RW'(1) - rc_reg;
        room = CAP_C - CW'(occ);
        in_end = first_frame + tff_pkg::pos_t'(frame_count);
        out_busy = ov_reg && !out_ready;
        slot_free = !out_busy;
        in_ready = (state_reg == S_IDLE) && slot_free;
        in_fire = in_valid && in_ready;
    end

    always_comb
    begin
        state_next = state_reg;
        wc_next = wc_reg; rc_next = rc_reg;
        pub_next = pub_reg; req_next = req_reg;
        pa_next = pa_reg; prem_next = prem_reg; pstart_next = pstart_reg;
        pidx_next = pidx_reg; pmark_next = pmark_reg;
        op2_next = op2_reg; target_next = target_reg; ostart_next = ostart_reg;
        oend_next = oend_reg; ocnt_next = ocnt_reg; i_next = i_reg;
        omark_next = omark_reg; disc_next = disc_reg; fidx_next = fidx_reg;
        ret_read_next = ret_read_reg;
        rd_en = 1'b0; rd_addr = slot(rc_reg);
        wr_en = 1'b0; wr_addr = slot(fidx_reg);
        wr_pay = '0; wr_pos = ostart_reg; wr_mark = omark_reg;
        ov_next = ov_reg && !out_ready;
        kind_next = kind_reg; ok_next = ok_reg; ex_next = ex_reg;
        dc_next = dc_reg; la_next = la_reg; dat_next = dat_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (opcode)
                        tff_pkg::OP_WRITE_BEGIN:
                        begin
                            pa_next = 1'b0;
                            prem_next = '0;
                            ov_next = 1'b1; kind_next = tff_pkg::KIND_WRITE;
                            ok_next = 1'b0; ex_next = 1'b0; dc_next = 1'b0;
                            la_next = 1'b1; dat_next = '0;
                            if (frame_count != '0 && frame_count <= CAP_C
                                && first_frame >= pub_reg)
                            begin
                                if (in_end <= req_reg || frame_count > room)
                                    pub_next = in_end;
                                else if (zero_fill)
                                begin
                                    ok_next = 1'b1;
                                    ov_next = 1'b0;
                                    ostart_next = first_frame;
                                    oend_next = in_end;
                                    ocnt_next = frame_count;
                                    omark_next = mark_discontinuity;
                                    fidx_next = wc_reg;
                                    state_next = S_FILL;
                                end
                                else
                                begin
                                    ok_next = 1'b1;
                                    pa_next = 1'b1;
                                    prem_next = frame_count;
                                    pstart_next = first_frame;
                                    pidx_next = wc_reg;
                                    pmark_next = mark_discontinuity;
                                end
                            end
                        end
                        tff_pkg::OP_WRITE_DATA:
                        begin
                            if (pa_reg && prem_reg != '0)
                            begin
                                wr_en = 1'b1;
                                wr_addr = slot(pidx_reg);
                                wr_pay = frame_data[FRAME_BITS-1:0];
                                wr_pos = pstart_reg;
                                wr_mark = pmark_reg;
                                pidx_next = ring_add(pidx_reg, CW'(1));
                                pstart_next = pstart_reg + tff_pkg::pos_t'(1);
                                prem_next = prem_reg - CW'(1);
                                if (prem_reg == CW'(1))
                                begin
                                    wc_next = ring_add(pidx_reg, CW'(1));
                                    pub_next = pstart_reg + tff_pkg::pos_t'(1);
                                    pa_next = 1'b0;
                                end
                            end
                        end
                        tff_pkg::OP_PUBLISH_GAP:
                        begin
                            if (first_frame >= pub_reg)
                                pub_next = in_end;
                        end
                        tff_pkg::OP_READ:
                        begin
                            if (frame_count != '0)
                            begin
                                req_next = in_end;
                                ostart_next = first_frame;
                                oend_next = in_end;
                                ocnt_next = frame_count;
                                target_next = first_frame;
                                op2_next = 2'd0;
                                ret_read_next = 1'b1;
                                state_next = S_DISC_A;
                            end
                        end
                        tff_pkg::OP_EXPIRE:
                        begin
                            req_next = until_frame;
                            target_next = until_frame;
                            ret_read_next = 1'b0;
                            state_next = S_DISC_A;
                        end
                        tff_pkg::OP_CAN_WRITE:
                        begin
                            ov_next = 1'b1; kind_next = tff_pkg::KIND_CAN;
                            ok_next = frame_count != '0 && frame_count <= CAP_C
                                && in_end > req_reg && frame_count <= room;
                            ex_next = 1'b0; dc_next = 1'b0; la_next = 1'b1;
                            dat_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_FILL:
            begin
                wr_en = 1'b1;
                wr_addr = slot(fidx_reg);
                wr_pay = '0;
                wr_pos = ostart_reg;
                wr_mark = omark_reg;
                fidx_next = ring_add(fidx_reg, CW'(1));
                ostart_next = ostart_reg + tff_pkg::pos_t'(1);
                ocnt_next = ocnt_reg - CW'(1);
                if (ocnt_reg == CW'(1))
                begin
                    wc_next = ring_add(fidx_reg, CW'(1));
                    pub_next = oend_reg;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DISC_A:
            begin
                if (rc_reg == wc_reg)
                    state_next = ret_read_reg ? S_CHK_A : S_IDLE;
                else
                begin
                    rd_en = 1'b1;
                    rd_addr = slot(rc_reg);
                    state_next = S_DISC_B;
                end
            end
            S_DISC_B:
            begin
                if (rd_pos < target_reg)
                begin
                    rc_next = ring_add(rc_reg, CW'(1));
                    state_next = S_DISC_A;
                end
                else
                    state_next = ret_read_reg ? S_CHK_A : S_IDLE;
            end
            S_CHK_A:
            begin
                if (op2_reg == 2'd1)
                begin
                    i_next = '0;
                    state_next = S_ZEROS;
                end
                else if (ocnt_reg <= CAP_C && CW'(occ) >= ocnt_reg)
                begin
                    rd_en = 1'b1;
                    rd_addr = slot(rc_reg);
                    i_next = '0;
                    state_next = S_CHK_B;
                end
                else
                begin
                    op2_next = 2'd1;
                    target_next = oend_reg;
                    state_next = S_DISC_A;
                end
            end
            S_CHK_B:
            begin
                // i=0: first position in rd_pos, fetch last; i=1: check last
                if (i_reg == '0)
                begin
                    if (rd_pos == ostart_reg)
                    begin
                        rd_en = 1'b1;
                        rd_addr = slot(ring_add(rc_reg, ocnt_reg - CW'(1)));
                        i_next = CW'(1);
                    end
                    else
                    begin
                        op2_next = 2'd1;
                        target_next = oend_reg;
                        state_next = S_DISC_A;
                    end
                end
                else if (rd_pos == oend_reg - tff_pkg::pos_t'(1))
                begin
                    i_next = '0;
                    disc_next = 1'b0;
                    state_next = S_MARK_A;
                end
                else
                begin
                    op2_next = 2'd1;
                    target_next = oend_reg;
                    state_next = S_DISC_A;
                end
            end
            S_MARK_A:
            begin
                rd_en = 1'b1;
                rd_addr = slot(ring_add(rc_reg, i_reg));
                state_next = S_MARK_B;
            end
            S_MARK_B:
            begin
                disc_next = disc_reg | rd_mark;
                i_next = i_reg + CW'(1);
                if (i_reg + CW'(1) == ocnt_reg)
                begin
                    i_next = '0;
                    state_next = S_EMIT_A;
                end
                else
                    state_next = S_MARK_A;
            end
            S_EMIT_A:
            begin
                if (slot_free)
                begin
                    rd_en = 1'b1;
                    rd_addr = slot(ring_add(rc_reg, i_reg));
                    state_next = S_EMIT_B;
                end
            end
            S_EMIT_B:
            begin
                ov_next = 1'b1; kind_next = tff_pkg::KIND_READ; ok_next = 1'b0;
                ex_next = 1'b1; dat_next = rd_pay;
                la_next = (i_reg + CW'(1) == ocnt_reg);
                dc_next = la_next && disc_reg;
                i_next = i_reg + CW'(1);
                if (la_next)
                begin
                    rc_next = ring_add(rc_reg, ocnt_reg);
                    state_next = S_IDLE;
                end
                else
                    state_next = S_EMIT_A;
            end
            S_ZEROS:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1; kind_next = tff_pkg::KIND_READ;
                    ok_next = 1'b0; ex_next = 1'b0; dat_next = '0;
                    la_next = (i_reg + CW'(1) == ocnt_reg)
                        || (i_reg + CW'(1) == CW'(tff_pkg::MAX_RES));
                    dc_next = la_next;
                    i_next = i_reg + CW'(1);
                    if (la_next)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wc_reg <= '0; rc_reg <= '0; pub_reg <= '0; req_reg <= '0;
            pa_reg <= 1'b0; prem_reg <= '0; pstart_reg <= '0;
            pidx_reg <= '0; pmark_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wc_reg <= wc_next; rc_reg <= rc_next;
            pub_reg <= pub_next; req_reg <= req_next;
            pa_reg <= pa_next; prem_reg <= prem_next; pstart_reg <= pstart_next;
            pidx_reg <= pidx_next; pmark_reg <= pmark_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op2_reg <= op2_next; target_reg <= target_next; ostart_reg <= ostart_next;
        oend_reg <= oend_next; ocnt_reg <= ocnt_next; i_reg <= i_next;
        omark_reg <= omark_next; disc_reg <= disc_next; fidx_reg <= fidx_next;
        ret_read_reg <= ret_read_next;
        kind_reg <= kind_next; ok_reg <= ok_next; ex_reg <= ex_next;
        dc_reg <= dc_next; la_reg <= la_next; dat_reg <= dat_next;
    end

    assign out_valid = ov_reg;
    assign result_kind = kind_reg;
    assign ok = ok_reg;
    assign frame_data_res = 64'(dat_reg);
    assign exact = ex_reg;
    assign discontinuity = dc_reg;
    assign last = la_reg;
endmodule
`default_nettype wire

[design/tff_checker.sv]
// Port-level checker for the timestamped frame FIFO, bound to the top level.
`default_nettype none
module tff_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  result_kind,
    input wire logic        ok,
    input wire logic [63:0] frame_data_res,
    input wire logic        exact,
    input wire logic        discontinuity,
    input wire logic        last
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_data_res))
        else $error("result dropped while stalled");
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_kind == tff_pkg::KIND_WRITE
            || result_kind == tff_pkg::KIND_READ || result_kind == tff_pkg::KIND_CAN)
        else $error("bad result kind");
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != tff_pkg::KIND_READ |-> last && !exact && !discontinuity)
        else $error("status result malformed");
    a_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == tff_pkg::KIND_READ |-> !ok
            && (exact || frame_data_res == 64'd0)
            && (last || !discontinuity))
        else $error("read result malformed");
endmodule

bind timestamped_frame_fifo tff_checker u_tff_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .ok(ok), .frame_data_res(frame_data_res),
    .exact(exact), .discontinuity(discontinuity), .last(last)
);
`default_nettype wire
